// ===== rtl/core/rod_pkg.sv =====
`default_nettype none

package rod_pkg;

    localparam int unsigned Levels5 = 31;
    localparam int unsigned Levels6 = 63;
    localparam logic [7:0]  MidThreshold = 8'd127;

    // Bayer 4x4 index matrix, entry (row*4 + column)
    localparam logic [3:0] BAYER [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10, 4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,  4'd15, 4'd7,  4'd13, 4'd5
    };

    localparam logic MODE_RGB888 = 1'b0;
    localparam logic MODE_RGB565 = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [1:0] col;
        logic [1:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [15:0] word;
    } pix_t;

    typedef struct packed {
        logic [7:0] byte_high;
        logic [7:0] byte_low;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rod_pixel_calc.sv =====
`default_nettype none

module rod_pixel_calc (
    input  rod_pkg::pix_t pix,
    input  logic          dither_en,
    output rod_pkg::res_t res
);
    import rod_pkg::*;

    // Rounded widening: equals (c*255 + half)/levels for every code
    function automatic logic [7:0] widen5(input logic [4:0] c);
        logic [13:0] acc;
        begin
            acc = {9'd0, c} * 14'd527 + 14'd23;
            widen5 = acc[13:6];
        end
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] c);
        logic [13:0] acc;
        begin
            acc = {8'd0, c} * 14'd259 + 14'd33;
            widen6 = acc[13:6];
        end
    endfunction

    // (c8*levels + t) / 255, clamped to levels; divide via n + 1 + (n >> 8), then >> 8
    function automatic logic [5:0] requant(input logic [7:0] c8, input logic [5:0] levels,
                                           input logic [7:0] t);
        logic [14:0] num;
        logic [14:0] adj;
        logic [6:0]  q;
        begin
            num = {7'd0, c8} * {9'd0, levels} + {7'd0, t};
            adj = num + 15'd1 + {8'd0, num[14:8]};
            q   = adj[14:8];
            if (q > {1'b0, levels})
                requant = levels;
            else
                requant = q[5:0];
        end
    endfunction

    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [11:0] bayer_scaled;
    logic [7:0]  thresh;
    logic [4:0]  rc;
    logic [5:0]  gc;
    logic [4:0]  bc;
    logic [5:0]  rc_full;
    logic [5:0]  bc_full;

    always_comb
    begin
        if (pix.mode == MODE_RGB565)
        begin
            r8 = widen5(pix.word[15:11]);
            g8 = widen6(pix.word[10:5]);
            b8 = widen5(pix.word[4:0]);
        end
        else
        begin
            r8 = pix.red;
            g8 = pix.green;
            b8 = pix.blue;
        end
    end

    assign bayer_scaled = {8'd0, BAYER[{pix.row, pix.col}]} * 12'd255;
    assign thresh       = dither_en ? bayer_scaled[11:4] : MidThreshold;

    assign rc_full = requant(r8, 6'(Levels5), thresh);
    assign gc      = requant(g8, 6'(Levels6), thresh);
    assign bc_full = requant(b8, 6'(Levels5), thresh);
    assign rc      = rc_full[4:0];
    assign bc      = bc_full[4:0];

    always_comb
    begin
        if (pix.mode == MODE_RGB565 && !dither_en)
        begin
            res.byte_high = pix.word[15:8];
            res.byte_low  = pix.word[7:0];
        end
        else
        begin
            res.byte_high = {rc, gc[5:3]};
            res.byte_low  = {gc[2:0], bc};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rgb565_ordered_dither.sv =====
// RGB565 ordered dither, one pixel per beat.
// Input channel: in_valid / in_stall with mode, column, row, red_in, green_in,
// blue_in and pixel_word. Mode 0 requantizes the 8-bit channels; mode 1 widens
// the RGB565 word and dithers it again (passed through if dither is off). Only
// the low two bits of column and row pick the Bayer 4x4 threshold.
// Output channel: out_valid / out_stall with byte_high and byte_low, the
// big-endian RGB565 result.
// Configuration: cfg_valid / cfg_ready / cfg_data writes dither_enable; the
// port is always ready. Write it only while no pixel is in flight.
// Pipeline: an accepted pixel waits in the input register, then its result
// goes to the output via the result register (two register stages).
// Throughput: one pixel per cycle while out_stall is low, set by the
// single-pass arithmetic between the two registers.
// Reset: both stages empty, dither_enable = 1.
// Stall: while out_stall is high the result holds; the input register keeps
// accepting until it is also full, then in_stall rises.
`default_nettype none

module rgb565_ordered_dither (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [15:0] column,
    input  logic [15:0] row,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [15:0] pixel_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_high,
    output logic [7:0]  byte_low
);
    import rod_pkg::*;

    logic dither_en_reg;
    logic dither_en_next;
    logic s1_valid_reg;
    logic s1_valid_next;
    pix_t s1_pix_reg;
    logic s2_valid_reg;
    logic s2_valid_next;
    res_t s2_res_reg;
    res_t calc_res;
    pix_t in_pix;
    logic s2_en;
    logic s1_en;
    logic in_take;

    assign cfg_ready = 1'b1;

    assign in_pix = '{mode: mode, col: column[1:0], row: row[1:0], red: red_in,
                      green: green_in, blue: blue_in, word: pixel_word};

    // Advance the result stage when it is empty or being drained
    assign s2_en    = !s2_valid_reg || !out_stall;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;
    assign in_take  = in_valid && s1_en;

    assign dither_en_next = (cfg_valid && cfg_ready) ? cfg_data : dither_en_reg;
    assign s1_valid_next  = s1_en ? in_valid : s1_valid_reg;
    assign s2_valid_next  = s2_en ? s1_valid_reg : s2_valid_reg;

    rod_pixel_calc u_calc (
        .pix       (s1_pix_reg),
        .dither_en (dither_en_reg),
        .res       (calc_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_en_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            dither_en_reg <= dither_en_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_pix_reg <= in_pix;
        if (s2_en && s1_valid_reg)
            s2_res_reg <= calc_res;
    end

    assign out_valid = s2_valid_reg;
    assign byte_high = s2_res_reg.byte_high;
    assign byte_low  = s2_res_reg.byte_low;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg))
        else $error("input stalled with a free stage");

    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat lost from input stage");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_en) |=> (s1_valid_reg && $stable(s1_pix_reg)))
        else $error("input stage changed while blocked");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !s1_valid_reg) |=> !out_valid)
        else $error("result repeated after drain");

    a_s1_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_en) |=> out_valid)
        else $error("input stage beat not moved to result stage");

endmodule

`default_nettype wire
